// File: rtl/rksdh_pkg.sv
// ----------------------------------------------------------------------------
// rksdh_pkg
// Shared types and constants for the running k-th smallest dual-heap block.
// ----------------------------------------------------------------------------
package rksdh_pkg;

    // Heap capacity and index widths.
    localparam int Capacity = 1024;
    localparam int AddrW    = $clog2(Capacity);
    localparam int CntW     = $clog2(Capacity + 1);

    // Operation codes.
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_ADD_DONE = 2'd0;
    localparam logic [1:0] ST_GET_DONE = 2'd1;
    localparam logic [1:0] ST_GET_EMPTY = 2'd2;
    localparam logic [1:0] ST_ADD_FULL = 2'd3;

    // Heap selector: low is the max-heap, high is the min-heap.
    typedef enum logic {
        HEAP_LOW  = 1'b0,
        HEAP_HIGH = 1'b1
    } t_heap_sel;

    // Datapath command.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,       // capture input item
        CMD_RD_TOP,     // read top of selected heap (root)
        CMD_PUSH_WR,    // write push value at count, grow count
        CMD_UP_RD,      // read parent of cursor
        CMD_UP_STEP,    // compare cursor value to parent, swap/move
        CMD_POP_RD,     // read last element
        CMD_POP_WR,     // write last element to root, shrink count
        CMD_DN_RDL,     // read left child
        CMD_DN_RDR,     // read right child
        CMD_DN_STEP     // pick child, swap/move
    } t_cmd;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_TOPRD, S_TOPWAIT, S_TOPCHK,
        S_PUSH, S_UPRD, S_UPWAIT, S_UPSTEP,
        S_POPRD, S_POPWAIT, S_POPWR, S_DNCHK, S_DNRDL, S_DNRDR, S_DNWAIT, S_DNSTEP,
        S_DONE
    } t_state;

    // Sequence phases: which push/pop runs next.
    typedef enum logic [2:0] {
        P_ADD_HI, P_ADD_MV_HI, P_ADD_POP_LO, P_ADD_PUSH_LO, P_GET_PUSH_LO, P_GET_POP_HI
    } t_phase;

    typedef struct packed {
        t_cmd      cmd;
        t_heap_sel sel;
        logic      push_top;  // push the captured top instead of the input value
        logic      out_load;  // load output register
        logic [1:0] out_status;
    } t_ctrl;

    typedef struct packed {
        logic op;
        logic full;
        logic low_empty;
        logic high_empty;
        logic low_gt;     // low top strictly greater than input value
        logic up_done;
        logic dn_done;
        logic has_right;
        logic out_busy;
    } t_stat;

endpackage

// File: rtl/running_kth_smallest_dual_heap_top.sv
// ----------------------------------------------------------------------------
// running_kth_smallest_dual_heap_top
// Running order statistic store built from a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (i_in_valid/o_in_ready) carries op and value. An add inserts
// the value; a get returns the next-smallest value not yet handed out.
// Output channel (o_out_valid/i_out_ready) carries one result per item with
// result_value and status (add done, get done, get empty, add full).
// One item is worked on at a time. A rejected add or an empty get goes
// straight to its result. An add reads the low top; if the low heap holds a
// top greater than the value, that top is pushed onto the high heap, the low
// heap is popped and the value is pushed there, else the value is pushed onto
// the high heap. A get pushes the high top onto the low heap and pops the high
// heap. A push sifts up, a pop sifts down, and the next item is taken only after the result is loaded.
// Reset clears both heap counts and the output valid flag; heap memories need
// no clearing since only counted entries are read.
// When the receiver stalls, the result holds in the output register and a new
// item is taken only once that result is transferred or is being transferred.
// ----------------------------------------------------------------------------
module running_kth_smallest_dual_heap_top import rksdh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status
);

    t_ctrl ctrl;
    t_stat stat;

    rksdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    rksdh_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_out_ready    (i_out_ready),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

// File: rtl/rksdh_datapath.sv
// ----------------------------------------------------------------------------
// rksdh_datapath
// Heap memories, counters, cursor and compare logic driven by the controller.
// ----------------------------------------------------------------------------
module rksdh_datapath import rksdh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl              i_ctrl,
    input  logic               i_op,
    input  logic signed [31:0] i_value,
    input  logic               i_out_ready,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status
);

    // Heap memories.
    logic signed [31:0] r_low_mem  [Capacity];
    logic signed [31:0] r_high_mem [Capacity];
    logic signed [31:0] r_rd_data;

    logic [CntW-1:0]    r_low_cnt, r_high_cnt, n_low_cnt, n_high_cnt;
    logic               r_op;
    logic signed [31:0] r_val, r_top, r_cur, r_left;
    logic [AddrW-1:0]   r_idx;
    logic               r_out_valid;
    logic signed [31:0] r_result;
    logic [1:0]         r_status;
    logic               r_wb_pend;
    logic               r_stop;

    logic [CntW-1:0]    sel_cnt;
    logic               wr_en;
    logic [AddrW-1:0]   wr_addr, rd_addr;
    logic signed [31:0] wr_data;
    logic               rd_en;
    logic [AddrW:0]     left_ix;
    logic [CntW-1:0]    left_w, right_w;
    logic               prior_up, right_better, prior_dn;
    logic signed [31:0] best;
    logic [AddrW-1:0]   best_ix;

    assign sel_cnt = (i_ctrl.sel == HEAP_LOW) ? r_low_cnt : r_high_cnt;
    assign left_ix = {r_idx, 1'b1};
    assign left_w  = CntW'(left_ix);
    assign right_w = left_w + CntW'(1);

    // Compare helpers; max-heap on low, min-heap on high. On the way down the
    // right child wins unless the left one is strictly better.
    assign prior_up = (i_ctrl.sel == HEAP_LOW) ? (r_cur > r_rd_data) : (r_cur < r_rd_data);
    assign right_better = o_stat.has_right &&
        ((i_ctrl.sel == HEAP_LOW) ? !(r_left > r_rd_data) : !(r_left < r_rd_data));
    assign best    = right_better ? r_rd_data : r_left;
    assign best_ix = right_better ? AddrW'(right_w) : AddrW'(left_w);
    assign prior_dn = (i_ctrl.sel == HEAP_LOW) ? (best > r_cur) : (best < r_cur);

    // Memory port addressing.
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_cur;
        case (i_ctrl.cmd)
            CMD_RD_TOP:  rd_addr = '0;
            CMD_UP_RD:   rd_addr = (r_idx - AddrW'(1)) >> 1;
            CMD_POP_RD:  rd_addr = AddrW'(sel_cnt - CntW'(1));
            CMD_DN_RDL:  rd_addr = AddrW'(left_w);
            CMD_DN_RDR:  rd_addr = AddrW'(right_w);
            CMD_PUSH_WR: begin
                wr_en   = 1'b1;
                wr_addr = AddrW'(sel_cnt);
                wr_data = i_ctrl.push_top ? r_top : r_val;
            end
            CMD_UP_STEP: begin
                // Move parent down into the cursor slot when it yields.
                wr_en   = prior_up;
                wr_data = r_rd_data;
            end
            CMD_POP_WR: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_rd_data;
            end
            CMD_DN_STEP: begin
                wr_en   = 1'b1;
                wr_data = prior_dn ? best : r_cur;
            end
            default: rd_en = 1'b0;
        endcase
        // After a move the cursor value lands in its new slot in the following cycle.
        if (r_wb_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
            wr_data = r_cur;
        end
    end

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en && i_ctrl.sel == HEAP_LOW) begin
            r_low_mem[wr_addr] <= wr_data;
        end
        if (wr_en && i_ctrl.sel == HEAP_HIGH) begin
            r_high_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= (i_ctrl.sel == HEAP_LOW) ? r_low_mem[rd_addr] : r_high_mem[rd_addr];
        end
    end

    // Counter updates.
    always_comb begin
        n_low_cnt  = r_low_cnt;
        n_high_cnt = r_high_cnt;
        if (i_ctrl.cmd == CMD_PUSH_WR) begin
            if (i_ctrl.sel == HEAP_LOW) n_low_cnt = r_low_cnt + CntW'(1);
            else                        n_high_cnt = r_high_cnt + CntW'(1);
        end else if (i_ctrl.cmd == CMD_POP_WR) begin
            if (i_ctrl.sel == HEAP_LOW) n_low_cnt = r_low_cnt - CntW'(1);
            else                        n_high_cnt = r_high_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt   <= '0;
            r_high_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_low_cnt  <= n_low_cnt;
            r_high_cnt <= n_high_cnt;
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sift bookkeeping: a move schedules the cursor write-back, and a compare
    // that does not move ends the sift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_pend <= 1'b0;
            r_stop    <= 1'b0;
        end else begin
            r_wb_pend <= ((i_ctrl.cmd == CMD_UP_STEP) && prior_up) ||
                         ((i_ctrl.cmd == CMD_DN_STEP) && prior_dn);
            case (i_ctrl.cmd)
                CMD_PUSH_WR, CMD_POP_WR: r_stop <= 1'b0;
                CMD_UP_STEP: begin
                    if (!prior_up) r_stop <= 1'b1;
                end
                CMD_DN_STEP: begin
                    if (!prior_dn) r_stop <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            CMD_LOAD: begin
                r_op  <= i_op;
                r_val <= i_value;
            end
            CMD_PUSH_WR: begin
                r_idx <= AddrW'(sel_cnt);
                r_cur <= i_ctrl.push_top ? r_top : r_val;
            end
            CMD_UP_STEP: begin
                if (prior_up) r_idx <= (r_idx - AddrW'(1)) >> 1;
            end
            CMD_POP_WR: begin
                r_idx <= '0;
                r_cur <= r_rd_data;
            end
            CMD_DN_RDR: r_left <= r_rd_data;
            CMD_DN_STEP: begin
                if (prior_dn) r_idx <= best_ix;
            end
            default: ;
        endcase
        if (i_ctrl.out_load) begin
            r_status <= i_ctrl.out_status;
            r_result <= (i_ctrl.out_status == ST_GET_DONE) ? r_top : 32'sd0;
        end
    end

    // Root read data lands in the cycle after CMD_RD_TOP; capture it then.
    logic r_top_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_pend <= 1'b0;
        end else begin
            r_top_pend <= (i_ctrl.cmd == CMD_RD_TOP);
        end
        if (r_top_pend) r_top <= r_rd_data;
    end

    // Status back to the controller.
    always_comb begin
        o_stat.op         = r_op;
        o_stat.full       = ({1'b0, r_low_cnt} + {1'b0, r_high_cnt}) >= (CntW+1)'(Capacity);
        o_stat.low_empty  = (r_low_cnt == '0);
        o_stat.high_empty = (r_high_cnt == '0);
        o_stat.low_gt     = (r_top > r_val);
        o_stat.up_done    = (r_idx == '0) || r_stop;
        o_stat.dn_done    = ~(left_w < sel_cnt) || r_stop;
        o_stat.has_right  = (right_w < sel_cnt);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;

endmodule

// File: rtl/rksdh_ctrl.sv
// ----------------------------------------------------------------------------
// rksdh_ctrl
// Sequencer for add and get items over the two heaps.
// ----------------------------------------------------------------------------
module rksdh_ctrl import rksdh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [1:0] r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_ADD_HI;
            r_st    <= ST_ADD_DONE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_st    <= n_st;
        end
    end

    // Phase to heap and push source.
    function automatic t_heap_sel f_sel(input t_phase p);
        case (p)
            P_ADD_HI, P_ADD_MV_HI, P_GET_POP_HI: f_sel = HEAP_HIGH;
            default:                             f_sel = HEAP_LOW;
        endcase
    endfunction

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_st    = r_st;
        o_in_ready         = 1'b0;
        o_ctrl.cmd         = CMD_NONE;
        o_ctrl.sel         = f_sel(r_phase);
        o_ctrl.push_top    = (r_phase == P_ADD_MV_HI) || (r_phase == P_GET_PUSH_LO);
        o_ctrl.out_load    = 1'b0;
        o_ctrl.out_status  = r_st;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_stat.out_busy;
                if (i_in_valid && !i_stat.out_busy) begin
                    o_ctrl.cmd = CMD_LOAD;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.op == OP_ADD) begin
                    if (i_stat.full) begin
                        n_st = ST_ADD_FULL; n_state = S_DONE;
                    end else begin
                        n_st = ST_ADD_DONE; n_phase = P_ADD_MV_HI; n_state = S_TOPRD;
                    end
                end else begin
                    if (i_stat.high_empty) begin
                        n_st = ST_GET_EMPTY; n_state = S_DONE;
                    end else begin
                        n_st = ST_GET_DONE; n_phase = P_GET_PUSH_LO; n_state = S_TOPRD;
                    end
                end
            end
            S_TOPRD: begin
                // Add inspects the low top, get takes the high top.
                o_ctrl.sel = (r_phase == P_ADD_MV_HI) ? HEAP_LOW : HEAP_HIGH;
                o_ctrl.cmd = CMD_RD_TOP;
                n_state = S_TOPWAIT;
            end
            S_TOPWAIT: n_state = S_TOPCHK;
            S_TOPCHK: begin
                if (r_phase == P_ADD_MV_HI && (i_stat.low_empty || !i_stat.low_gt)) begin
                    n_phase = P_ADD_HI;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_ctrl.cmd = CMD_PUSH_WR;
                n_state = S_UPRD;
            end
            S_UPRD: begin
                if (i_stat.up_done) begin
                    n_state = S_DONE;
                    case (r_phase)
                        P_ADD_MV_HI: begin n_phase = P_ADD_POP_LO; n_state = S_POPRD; end
                        P_GET_PUSH_LO: begin n_phase = P_GET_POP_HI; n_state = S_POPRD; end
                        default: ;
                    endcase
                end else begin
                    o_ctrl.cmd = CMD_UP_RD;
                    n_state = S_UPWAIT;
                end
            end
            S_UPWAIT: n_state = S_UPSTEP;
            S_UPSTEP: begin
                o_ctrl.cmd = CMD_UP_STEP;
                n_state = S_UPRD;
            end
            S_POPRD: begin
                o_ctrl.cmd = CMD_POP_RD;
                n_state = S_POPWAIT;
            end
            S_POPWAIT: n_state = S_POPWR;
            S_POPWR: begin
                o_ctrl.cmd = CMD_POP_WR;
                n_state = S_DNCHK;
            end
            S_DNCHK: begin
                if (i_stat.dn_done) begin
                    if (r_phase == P_ADD_POP_LO) begin
                        n_phase = P_ADD_PUSH_LO; n_state = S_PUSH;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DNRDL;
                end
            end
            S_DNRDL: begin
                o_ctrl.cmd = CMD_DN_RDL;
                n_state = S_DNRDR;
            end
            S_DNRDR: begin
                o_ctrl.cmd = CMD_DN_RDR;
                n_state = S_DNWAIT;
            end
            S_DNWAIT: n_state = S_DNSTEP;
            S_DNSTEP: begin
                o_ctrl.cmd = CMD_DN_STEP;
                n_state = S_DNCHK;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: sim/rksdh_scoreboard.sv
// ----------------------------------------------------------------------------
// rksdh_scoreboard
// Watches both channels of the dual-heap order statistic store, keeps its own
// pair of heaps to predict each result, and compares every output transfer
// with the oldest prediction.
// ----------------------------------------------------------------------------
module rksdh_scoreboard import rksdh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_op,
    input  logic signed [31:0] i_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_result_value,
    input  logic [1:0]         i_status,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_answer;

    // Predicted heap contents: low is the max-heap, high is the min-heap.
    logic signed [31:0] low_mem [Capacity];
    logic signed [31:0] high_mem[Capacity];
    int                 low_cnt;
    int                 high_cnt;
    int                 err_cnt = 0;
    t_answer            answers_q[$];

    // True when a must sit strictly above b in the selected heap.
    function automatic bit outranks(t_heap_sel sel, logic signed [31:0] a,
                                    logic signed [31:0] b);
        return (sel == HEAP_HIGH) ? (a < b) : (a > b);
    endfunction

    function automatic logic signed [31:0] heap_rd(t_heap_sel sel, int idx);
        return (sel == HEAP_HIGH) ? high_mem[idx] : low_mem[idx];
    endfunction

    function automatic void heap_wr(t_heap_sel sel, int idx, logic signed [31:0] v);
        if (sel == HEAP_HIGH) begin
            high_mem[idx] = v;
        end else begin
            low_mem[idx] = v;
        end
    endfunction

    function automatic void heap_swap(t_heap_sel sel, int a, int b);
        logic signed [31:0] t;
        t = heap_rd(sel, a);
        heap_wr(sel, a, heap_rd(sel, b));
        heap_wr(sel, b, t);
    endfunction

    // Insert at the end and sift up; ties stay in place.
    function automatic void heap_insert(t_heap_sel sel, logic signed [31:0] v);
        int i;
        int p;
        i = (sel == HEAP_HIGH) ? high_cnt : low_cnt;
        heap_wr(sel, i, v);
        if (sel == HEAP_HIGH) begin
            high_cnt++;
        end else begin
            low_cnt++;
        end
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!outranks(sel, heap_rd(sel, i), heap_rd(sel, p))) break;
            heap_swap(sel, i, p);
            i = p;
        end
    endfunction

    // Remove the root and sift the last entry down; the right child is taken
    // unless the left one is strictly better.
    function automatic void heap_remove_top(t_heap_sel sel);
        int n;
        int i;
        int c;
        n = ((sel == HEAP_HIGH) ? high_cnt : low_cnt) - 1;
        heap_wr(sel, 0, heap_rd(sel, n));
        if (sel == HEAP_HIGH) begin
            high_cnt = n;
        end else begin
            low_cnt = n;
        end
        i = 0;
        while (2 * i + 1 < n) begin
            c = 2 * i + 1;
            if (c + 1 < n && !outranks(sel, heap_rd(sel, c), heap_rd(sel, c + 1))) c++;
            if (!outranks(sel, heap_rd(sel, c), heap_rd(sel, i))) break;
            heap_swap(sel, i, c);
            i = c;
        end
    endfunction

    // Work out the answer to one accepted item and update the heaps.
    function automatic t_answer order_stat_step(logic op, logic signed [31:0] v);
        t_answer a;
        logic signed [31:0] top;
        a.value = '0;
        if (op == OP_ADD) begin
            if (low_cnt + high_cnt >= Capacity) begin
                a.status = ST_ADD_FULL;
            end else begin
                if (low_cnt > 0 && low_mem[0] > v) begin
                    top = low_mem[0];
                    heap_insert(HEAP_HIGH, top);
                    heap_remove_top(HEAP_LOW);
                    heap_insert(HEAP_LOW, v);
                end else begin
                    heap_insert(HEAP_HIGH, v);
                end
                a.status = ST_ADD_DONE;
            end
        end else begin
            if (high_cnt == 0) begin
                a.status = ST_GET_EMPTY;
            end else begin
                top = high_mem[0];
                a.value = top;
                heap_insert(HEAP_LOW, top);
                heap_remove_top(HEAP_HIGH);
                a.status = ST_GET_DONE;
            end
        end
        return a;
    endfunction

    // Predict on input transfers, compare on output transfers.
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (!i_rst_n) begin
            low_cnt  = 0;
            high_cnt = 0;
            answers_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                answers_q.insert(answers_q.size(), order_stat_step(i_op, i_value));
            end
            if (i_out_valid && i_out_ready) begin
                if (answers_q.size() == 0) begin
                    $display("%0t: unexpected result: actual value %0d status %0d",
                             $time, i_result_value, i_status);
                    err_cnt++;
                end else begin
                    exp_a = answers_q.pop_front();
                    if (exp_a.value !== i_result_value) begin
                        $display("%0t: result_value mismatch: expected %0d actual %0d",
                                 $time, exp_a.value, i_result_value);
                        err_cnt++;
                    end
                    if (exp_a.status !== i_status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, exp_a.status, i_status);
                        err_cnt++;
                    end
                end
            end
        end
        o_pending <= answers_q.size();
        o_fill    <= low_cnt + high_cnt;
    end

    assign o_errors = err_cnt;

endmodule

// File: sim/running_kth_smallest_dual_heap_top_tb.sv
// ----------------------------------------------------------------------------
// running_kth_smallest_dual_heap_top_tb
// Drives adds and gets into the order statistic store under random flow
// control, fills it past capacity, and reports the scoreboard's verdict.
// ----------------------------------------------------------------------------
module running_kth_smallest_dual_heap_top_tb import rksdh_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_op;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_result_value;
    logic [1:0]         o_status;

    int errors;
    int pending;
    int fill;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_seq;
    int hold_seen = 0;
    int hold_cnt  = 0;

    running_kth_smallest_dual_heap_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    rksdh_scoreboard u_scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_value (o_result_value),
        .i_status       (o_status),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_fill         (fill)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_cnt    <= 400;
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one item and hold it until its transfer.
    task automatic send_item(logic op, logic signed [31:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Values biased toward extremes and small ranges so ties happen often.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(16)) - 8;
            2:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(2000)) - 1000;
        endcase
    endfunction

    // Let the pending count take in the last transfer before waiting for it to drain.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (150) @(posedge i_clk);
    endtask

    // Fail-safe limit on the run.
    initial begin
        #5ms;
        $display("[running_kth_smallest_dual_heap_top] ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_ADD;
        i_value     = '0;
        hold_seq    = 0;
        tx_idle_pct = 13;
        rx_idle_pct = 88;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty get, extremes, ties, low-top displacement, drain.
        send_item(OP_GET, 32'sd5);
        send_item(OP_ADD, 32'sh7fffffff);
        send_item(OP_ADD, 32'sh80000000);
        send_item(OP_ADD, 32'sd0);
        send_item(OP_ADD, -32'sd1);
        send_item(OP_ADD, 32'sd0);
        send_item(OP_GET, 32'sd0);
        send_item(OP_GET, 32'sd0);
        send_item(OP_ADD, 32'sh80000000);
        send_item(OP_ADD, -32'sd1);
        send_item(OP_ADD, 32'sd3);
        send_item(OP_GET, 32'sd0);
        send_item(OP_GET, 32'sd0);
        send_item(OP_GET, 32'sd0);
        send_item(OP_GET, 32'sd0);
        send_item(OP_GET, 32'sd0);
        send_item(OP_GET, 32'sd0);
        send_item(OP_GET, -32'sd1);
        send_item(OP_ADD, 32'sh55555555);
        send_item(OP_ADD, 32'shaaaaaaaa);
        drain();

        // Sender rarely idles, receiver mostly stalls; mixed traffic.
        tx_idle_pct = 13;
        rx_idle_pct = 88;
        repeat (120) send_item($urandom_range(1) ? OP_GET : OP_ADD, pick_value());
        drain();

        // Swapped idling; long receiver hold-off, then fill to capacity.
        tx_idle_pct = 88;
        rx_idle_pct = 13;
        hold_seq    = hold_seq + 1;
        repeat (10) send_item(OP_ADD, pick_value());
        while (fill < Capacity) begin
            send_item(($urandom_range(99) < 4) ? OP_GET : OP_ADD, pick_value());
        end
        drain();

        // No idling: rejected adds at full, then gets and mixed traffic.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (8) send_item(OP_ADD, pick_value());
        repeat (30) send_item(OP_GET, pick_value());
        repeat (30) send_item($urandom_range(1) ? OP_GET : OP_ADD, pick_value());
        drain();

        if (errors == 0 && pending == 0) begin
            $display("[running_kth_smallest_dual_heap_top] OK");
        end else begin
            $display("[running_kth_smallest_dual_heap_top] ERROR");
        end
        $finish;
    end

endmodule
